// ===== hdl/psl_pkg.sv =====
package psl_pkg;

    localparam int ENTRIES     = 1024;
    localparam int ADDR_W      = $clog2(ENTRIES);
    localparam int IDX_W       = ADDR_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] MIN_FRAME_LEN  = 16'd34;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    typedef struct packed {
        logic [15:0] frame_len;
        logic [15:0] ether_type;
        logic [31:0] src_ip;
    } t_in;

    typedef struct packed {
        logic        counted;
        logic [63:0] packet_count;
        logic        new_entry;
        logic        evicted;
        logic [31:0] evicted_ip;
    } t_out;

    // classified beat handed from front to back
    typedef struct packed {
        logic        counted;
        logic [31:0] key;
    } t_job;

endpackage

// ===== hdl/psl_front.sv =====
module psl_front
    import psl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic o_job_vld,
    output t_job o_job,
    input  logic i_job_take
);

    t_job                r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QPTR_W:0]     r_cnt;
    logic                w_push, w_pop;
    t_job                w_job;

    assign full      = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_job_vld = (r_cnt != '0);
    assign o_job     = r_q[r_rp];
    assign w_push    = push && !full;
    assign w_pop     = i_job_take && o_job_vld;

    always_comb begin
        w_job.counted = (i_item.frame_len >= MIN_FRAME_LEN) &&
                        (i_item.ether_type == ETHERTYPE_IPV4);
        w_job.key     = i_item.src_ip;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hdl/psl_back.sv =====
module psl_back
    import psl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_vld,
    input  t_job i_job,
    output logic o_job_take,
    output logic o_res_vld,
    output t_out o_res,
    input  logic i_res_take
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_PROMO  = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    // table storage; valid entries are always slots 0 .. fill-1
    logic [31:0]       key_mem  [ENTRIES];
    logic [63:0]       cnt_mem  [ENTRIES];
    logic [ADDR_W-1:0] rank_mem [ENTRIES];

    logic [31:0]       rd_key;
    logic [63:0]       rd_cnt;
    logic [ADDR_W-1:0] rd_rank;

    t_state            r_state;
    logic [IDX_W-1:0]  r_fill, r_idx, r_limit;
    logic              r_pend;
    logic [ADDR_W-1:0] r_pidx;
    t_job              r_job;
    logic              r_hit, r_vic;
    logic [ADDR_W-1:0] r_hit_idx, r_vic_idx, r_target, r_old_rank;
    logic [ADDR_W-1:0] r_hit_rank, r_vic_rank;
    logic [63:0]       r_hit_cnt;
    logic [31:0]       r_vic_key;
    logic              r_age_all;
    t_out              r_res;
    logic              r_out_vld;
    t_out              r_out;

    logic              key_we, cnt_we, rank_we;
    logic [ADDR_W-1:0] key_wa, cnt_wa, rank_wa;
    logic [63:0]       cnt_wd;
    logic [ADDR_W-1:0] rank_wd;
    logic              issue;
    logic              out_free;
    logic              out_load;

    assign out_free   = !r_out_vld || i_res_take;
    assign out_load   = (r_state == S_RESULT) && out_free;
    assign o_res_vld  = r_out_vld;
    assign o_res      = r_out;
    assign o_job_take = (r_state == S_IDLE);
    assign issue      = ((r_state == S_SCAN) && (r_idx < r_fill)) ||
                        ((r_state == S_PROMO) && (r_idx < r_limit));

    // memory write ports
    always_comb begin
        key_we  = 1'b0;
        key_wa  = r_target;
        cnt_we  = 1'b0;
        cnt_wa  = r_target;
        cnt_wd  = 64'd1;
        rank_we = 1'b0;
        rank_wa = r_target;
        rank_wd = '0;
        if (r_state == S_DECIDE) begin
            rank_we = 1'b1;
            cnt_we  = 1'b1;
            if (r_hit) begin
                rank_wa = r_hit_idx;
                cnt_wa  = r_hit_idx;
                cnt_wd  = (r_hit_cnt == '1) ? r_hit_cnt : r_hit_cnt + 64'd1;
            end else if (r_fill < IDX_W'(ENTRIES)) begin
                key_we  = 1'b1;
                key_wa  = r_fill[ADDR_W-1:0];
                cnt_wa  = r_fill[ADDR_W-1:0];
                rank_wa = r_fill[ADDR_W-1:0];
            end else begin
                key_we  = 1'b1;
                key_wa  = r_vic_idx;
                cnt_wa  = r_vic_idx;
                rank_wa = r_vic_idx;
            end
        end else if (r_state == S_PROMO && r_pend && r_pidx != r_target &&
                     (r_age_all || rd_rank < r_old_rank)) begin
            rank_we = 1'b1;
            rank_wa = r_pidx;
            rank_wd = rd_rank + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we)  key_mem[key_wa]   <= r_job.key;
        if (cnt_we)  cnt_mem[cnt_wa]   <= cnt_wd;
        if (rank_we) rank_mem[rank_wa] <= rank_wd;
        rd_key  <= key_mem[r_idx[ADDR_W-1:0]];
        rd_cnt  <= cnt_mem[r_idx[ADDR_W-1:0]];
        rd_rank <= rank_mem[r_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_vic     <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_res_take) begin
                r_out_vld <= 1'b0;
            end
            r_pend <= issue;
            r_pidx <= r_idx[ADDR_W-1:0];
            if (issue) r_idx <= r_idx + 1'b1;

            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    r_hit <= 1'b0;
                    r_vic <= 1'b0;
                    if (i_job_vld) begin
                        r_job <= i_job;
                        r_res <= '0;
                        r_state <= i_job.counted ? S_SCAN : S_RESULT;
                    end
                end
                S_SCAN: begin
                    if (r_pend) begin
                        if (!r_hit && rd_key == r_job.key) begin
                            r_hit      <= 1'b1;
                            r_hit_idx  <= r_pidx;
                            r_hit_cnt  <= rd_cnt;
                            r_hit_rank <= rd_rank;
                        end
                        if (!r_vic || rd_rank > r_vic_rank) begin
                            r_vic      <= 1'b1;
                            r_vic_idx  <= r_pidx;
                            r_vic_rank <= rd_rank;
                            r_vic_key  <= rd_key;
                        end
                    end
                    if (!issue && !r_pend) r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_idx           <= '0;
                    r_limit         <= r_fill;
                    r_res.counted   <= 1'b1;
                    r_res.new_entry <= !r_hit;
                    r_res.packet_count <= cnt_wd;
                    r_age_all       <= 1'b0;
                    if (r_hit) begin
                        r_target   <= r_hit_idx;
                        r_old_rank <= r_hit_rank;
                    end else if (r_fill < IDX_W'(ENTRIES)) begin
                        // new slot: every valid entry ages
                        r_target  <= r_fill[ADDR_W-1:0];
                        r_age_all <= 1'b1;
                        r_fill    <= r_fill + 1'b1;
                    end else begin
                        r_target   <= r_vic_idx;
                        r_old_rank <= r_vic_rank;
                        r_res.evicted    <= 1'b1;
                        r_res.evicted_ip <= r_vic_key;
                    end
                    r_state <= S_PROMO;
                end
                S_PROMO: begin
                    if (!issue && !r_pend) r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/per_source_ip_lru_packet_counter_unit.sv =====
// Per-source IPv4 packet counter with an exact-LRU table of ENTRIES sources.
// Input side is a queue: drive i_item and push; the beat is taken when push
// is high and full is low. A front stage classifies the beat (frame length at
// least 34 bytes and ethertype IPv4) and parks it in a 2-deep queue.
// Result side is a queue too: while empty is low, o_result holds the oldest
// result; pop with empty low takes it. Exactly one result per input beat.
// The back engine sweeps the table memories one slot a cycle: a lookup pass
// over the n filled slots (key, count, rank read together), a decide step
// that writes count and rank of the chosen slot (and its key on a miss), then
// an aging pass over the same n slots. A beat that is not counted skips all
// three. The engine takes a new beat only once the last result has gone to
// the output register; the table memories have a single read port, which is
// why both passes go slot by slot.
// Slots fill from 0 upward and are never freed, so a fill count stands for
// the valid bits: reset clears it at once and no clearing pass is needed.
// Reset (i_rst_n low, synchronous) empties the queues and the table.
// When the receiver does not pop, the result sits in the output register,
// the back engine holds its next result, and full rises once the front
// queue is taken up.
module per_source_ip_lru_packet_counter_unit
    import psl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_result
);

    logic job_vld, job_take, res_vld;
    t_job job;

    psl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .o_job_vld  (job_vld),
        .o_job      (job),
        .i_job_take (job_take)
    );

    psl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_vld  (job_vld),
        .i_job      (job),
        .o_job_take (job_take),
        .o_res_vld  (res_vld),
        .o_res      (o_result),
        .i_res_take (pop)
    );

    assign empty = !res_vld;

endmodule

// ===== tb/per_source_ip_lru_packet_counter_unit_tb.sv =====
module per_source_ip_lru_packet_counter_unit_tb;
    import psl_pkg::*;

    // a counted beat sweeps the whole table twice once the table is full
    localparam int STALL_LIMIT = 40000;
    localparam int KEY_POOL    = 24;
    localparam t_out RES_NONE  = '0;

    typedef struct packed {
        t_in  item;
        logic typed;    // expected result given in the row
        t_out res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    t_in  i_item;
    logic empty;
    logic pop;
    t_out o_result;

    per_source_ip_lru_packet_counter_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // shadow copy of the flow table
    logic        tbl_valid [ENTRIES];
    logic [31:0] tbl_key   [ENTRIES];
    logic [63:0] tbl_count [ENTRIES];
    int          tbl_age   [ENTRIES];
    int          tbl_used;

    t_out        result_q [$];
    t_row        dir_rows [$];
    logic [31:0] key_pool [KEY_POOL];
    int          errors = 0;
    int          stall_cnt;
    int          pop_idle;
    bit          quiet;     // no idling near the end

    function automatic t_out mk_res(logic c, logic [63:0] n, logic ne, logic ev,
                                    logic [31:0] eip);
        t_out r;
        r.counted      = c;
        r.packet_count = n;
        r.new_entry    = ne;
        r.evicted      = ev;
        r.evicted_ip   = eip;
        return r;
    endfunction

    function automatic t_in mk_item(logic [15:0] len, logic [15:0] et, logic [31:0] ip);
        t_in it;
        it.frame_len  = len;
        it.ether_type = et;
        it.src_ip     = ip;
        return it;
    endfunction

    // entries younger than old_age grow one older, slot s becomes newest
    task automatic make_newest(input int s, input int old_age);
        for (int i = 0; i < ENTRIES; i++) begin
            if (i != s && tbl_valid[i] && tbl_age[i] < old_age)
                tbl_age[i]++;
        end
        tbl_age[s] = 0;
    endtask

    task automatic count_packet(input t_in it, output t_out r);
        int hit;
        int free_s;
        int lru;
        int lru_age;
        hit     = -1;
        free_s  = -1;
        lru     = -1;
        lru_age = 0;
        r = '0;
        if (it.frame_len < MIN_FRAME_LEN || it.ether_type != ETHERTYPE_IPV4)
            return;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                if (hit < 0 && tbl_key[i] == it.src_ip)
                    hit = i;
                if (lru < 0 || tbl_age[i] > lru_age) begin
                    lru     = i;
                    lru_age = tbl_age[i];
                end
            end else if (free_s < 0) begin
                free_s = i;
            end
        end
        r.counted = 1'b1;
        if (hit >= 0) begin
            if (tbl_count[hit] != '1)
                tbl_count[hit] = tbl_count[hit] + 64'd1;
            make_newest(hit, tbl_age[hit]);
            r.packet_count = tbl_count[hit];
            return;
        end
        r.new_entry    = 1'b1;
        r.packet_count = 64'd1;
        if (free_s >= 0) begin
            tbl_valid[free_s] = 1'b1;
            tbl_key[free_s]   = it.src_ip;
            tbl_count[free_s] = 64'd1;
            tbl_used++;
            make_newest(free_s, ENTRIES);
            return;
        end
        r.evicted    = 1'b1;
        r.evicted_ip = tbl_key[lru];
        tbl_key[lru]   = it.src_ip;
        tbl_count[lru] = 64'd1;
        make_newest(lru, lru_age);
    endtask

    // drive one beat, hold until taken, then maybe idle
    task automatic send_beat(input t_in it, input logic typed, input t_out res);
        t_out pred;
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        count_packet(it, pred);
        result_q.push_back(typed ? res : pred);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    function automatic t_in rand_counted(logic [31:0] ip);
        logic [15:0] len;
        case ($urandom_range(0, 3))
            0: len = MIN_FRAME_LEN;
            1: len = 16'hFFFF;
            default: len = 16'($urandom_range(34, 65535));
        endcase
        return mk_item(len, ETHERTYPE_IPV4, ip);
    endfunction

    // frames that must not be counted, near and far from the limits
    function automatic t_in rand_noise();
        logic [15:0] len;
        logic [15:0] et;
        len = 16'($urandom);
        et  = 16'($urandom);
        case ($urandom_range(0, 2))
            0: begin
                et  = ETHERTYPE_IPV4;
                len = 16'($urandom_range(0, 33));
            end
            1: et = ETHERTYPE_IPV4 ^ (16'd1 << $urandom_range(0, 15));
            default: ;
        endcase
        return mk_item(len, et, $urandom);
    endfunction

    // result side: random pop bursts, compare, watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop       <= 1'b0;
            stall_cnt <= 0;
            pop_idle  <= 0;
        end else begin
            if (pop && !empty) begin
                t_out want;
                stall_cnt <= 0;
                if (result_q.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %p", $time, o_result);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    if (o_result.counted !== want.counted) begin
                        $display("%0t: counted expected %0b actual %0b",
                                 $time, want.counted, o_result.counted);
                        errors++;
                    end
                    if (o_result.packet_count !== want.packet_count) begin
                        $display("%0t: packet_count expected %0d actual %0d",
                                 $time, want.packet_count, o_result.packet_count);
                        errors++;
                    end
                    if (o_result.new_entry !== want.new_entry) begin
                        $display("%0t: new_entry expected %0b actual %0b",
                                 $time, want.new_entry, o_result.new_entry);
                        errors++;
                    end
                    if (o_result.evicted !== want.evicted) begin
                        $display("%0t: evicted expected %0b actual %0b",
                                 $time, want.evicted, o_result.evicted);
                        errors++;
                    end
                    if (o_result.evicted_ip !== want.evicted_ip) begin
                        $display("%0t: evicted_ip expected %h actual %h",
                                 $time, want.evicted_ip, o_result.evicted_ip);
                        errors++;
                    end
                end
            end else if (push && !full) begin
                stall_cnt <= 0;
            end else begin
                stall_cnt <= stall_cnt + 1;
                if (stall_cnt >= STALL_LIMIT) begin
                    $display("per_source_ip_lru_packet_counter_unit test failed");
                    $finish;
                end
            end
            // receiver stall bursts
            if (pop_idle > 0) begin
                pop_idle <= pop_idle - 1;
                pop      <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                pop_idle <= $urandom_range(0, 6);
                pop      <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        t_row row;
        t_in  it;
        quiet    = 1'b0;
        i_rst_n  = 1'b0;
        push     = 1'b0;
        i_item   = '0;
        tbl_used = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_count[i] = '0;
            tbl_age[i]   = 0;
        end
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = $urandom;

        // directed rows: limits of the length and ethertype checks, key extremes
        dir_rows.push_back({mk_item(16'd33, ETHERTYPE_IPV4, 32'h0A000001), 1'b1,
                            RES_NONE});
        dir_rows.push_back({mk_item(16'd0, 16'h0000, 32'h0), 1'b1, RES_NONE});
        dir_rows.push_back({mk_item(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF), 1'b1,
                            RES_NONE});
        dir_rows.push_back({mk_item(16'd34, 16'h0801, 32'h0A000001), 1'b1,
                            RES_NONE});
        dir_rows.push_back({mk_item(16'd34, 16'h86DD, 32'h0A000001), 1'b1,
                            RES_NONE});
        dir_rows.push_back({mk_item(16'd34, ETHERTYPE_IPV4, 32'h0), 1'b1,
                            mk_res(1'b1, 64'd1, 1'b1, 1'b0, 32'd0)});
        dir_rows.push_back({mk_item(16'hFFFF, ETHERTYPE_IPV4, 32'hFFFFFFFF), 1'b1,
                            mk_res(1'b1, 64'd1, 1'b1, 1'b0, 32'd0)});
        dir_rows.push_back({mk_item(16'd35, ETHERTYPE_IPV4, 32'h0), 1'b1,
                            mk_res(1'b1, 64'd2, 1'b0, 1'b0, 32'd0)});
        dir_rows.push_back({mk_item(16'd1500, ETHERTYPE_IPV4, 32'hFFFFFFFF), 1'b1,
                            mk_res(1'b1, 64'd2, 1'b0, 1'b0, 32'd0)});
        // not counted: a known key must not move
        dir_rows.push_back({mk_item(16'd20, ETHERTYPE_IPV4, 32'h0), 1'b1,
                            RES_NONE});
        dir_rows.push_back({mk_item(16'd64, ETHERTYPE_IPV4, 32'h0), 1'b0, RES_NONE});
        dir_rows.push_back({mk_item(16'd64, ETHERTYPE_IPV4, 32'h80000000), 1'b0,
                            RES_NONE});
        dir_rows.push_back({mk_item(16'd64, ETHERTYPE_IPV4, 32'h00000001), 1'b0,
                            RES_NONE});
        dir_rows.push_back({mk_item(16'd64, ETHERTYPE_IPV4, 32'hFFFFFFFF), 1'b0,
                            RES_NONE});
        dir_rows.push_back({mk_item(16'd64, ETHERTYPE_IPV4, 32'h80000000), 1'b0,
                            RES_NONE});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_beat(row.item, row.typed, row.res);
        end

        // small working set: hits, fresh keys and noise
        for (int n = 0; n < 100; n++) begin
            if ($urandom_range(0, 3) == 0)
                it = rand_noise();
            else if ($urandom_range(0, 7) == 0)
                it = rand_counted($urandom);
            else
                it = rand_counted(key_pool[$urandom_range(0, KEY_POOL - 1)]);
            send_beat(it, 1'b0, '0);
        end

        // hold off until the table has drained all results
        push <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);

        // fill the rest of the table with fresh keys so that later misses evict
        while (tbl_used < ENTRIES)
            send_beat(rand_counted($urandom), 1'b0, '0);

        // full table: evictions mixed with hits on recent keys; last part idle-free
        for (int n = 0; n < 120; n++) begin
            if (n == 80)
                quiet = 1'b1;
            case ($urandom_range(0, 3))
                0: send_beat(rand_noise(), 1'b0, '0);
                1: send_beat(rand_counted(i_item.src_ip), 1'b0, '0);
                default: send_beat(rand_counted($urandom), 1'b0, '0);
            endcase
        end
        push <= 1'b0;

        while (result_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("per_source_ip_lru_packet_counter_unit test passed");
        end else begin
            $display("per_source_ip_lru_packet_counter_unit test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/psl_pkg.sv
hdl/psl_front.sv
hdl/psl_back.sv
hdl/per_source_ip_lru_packet_counter_unit.sv
tb/per_source_ip_lru_packet_counter_unit_tb.sv
